// ----- sv/clas_pkg.sv -----
package clas_pkg;

    // Character and counter widths
    localparam int CHAR_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int RUN_BITS   = 16;
    localparam int FIELD_BITS = 16;
    localparam int SUM_BITS   = ((COUNT_BITS > RUN_BITS) ? COUNT_BITS : RUN_BITS) + 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;

    // Character codes of interest
    localparam logic [FIELD_BITS-1:0] C_NUL   = 16'd0;
    localparam logic [FIELD_BITS-1:0] C_TAB   = 16'd9;
    localparam logic [FIELD_BITS-1:0] C_SPACE = 16'd32;
    localparam logic [FIELD_BITS-1:0] C_QUOTE = 16'd34;
    localparam logic [FIELD_BITS-1:0] C_SLASH = 16'd92;

    // Parser state carried from one item to the next
    typedef struct packed {
        logic                  in_arg;
        logic                  in_quotes;
        logic                  quote_pend;
        logic [RUN_BITS-1:0]   bs_run;
        logic [COUNT_BITS-1:0] args;
        logic [COUNT_BITS-1:0] chars;
    } t_state;

    localparam t_state STATE_RESET = '0;

    // One result item plus its presence flag
    typedef struct packed {
        logic                  produce;
        logic [FIELD_BITS-1:0] slash_run;
        logic                  char_valid;
        logic [FIELD_BITS-1:0] out_char;
        logic                  arg_end;
        logic                  line_end;
        logic [FIELD_BITS-1:0] arg_count;
        logic [FIELD_BITS-1:0] char_count;
    } t_res;

endpackage

// ----- sv/command_line_argument_splitter.sv -----
// Datapath: an accepted character is held in the input register, then its result in the result register.
// Throughput: one character per cycle while the result register is free or being emptied; clas_step updates r_st.
// Characters that yield no result (separators between arguments, backslashes, quote toggles) still step the parser.
// Reset: synchronous, active low; clears parser state, counters and both valid flags.
module command_line_argument_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] ch
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [15:0] slash_run, [31:16] out_char,
                                     // [47:32] arg_count, [63:48] char_count
    output logic [1:0]  o_m_tuser,   // [0] char_valid, [1] arg_end
    output logic        o_m_tlast    // line_end
);
    import clas_pkg::*;

    logic        r_in_valid, n_in_valid;
    logic [15:0] r_in_ch;
    t_state      r_st, n_st;
    logic        r_out_valid, n_out_valid;
    t_res        r_out;
    t_res        step_res;
    logic        adv;

    // Step logic between input and result registers
    clas_step u_step (
        .i_ch    (r_in_ch),
        .i_state (r_st),
        .o_state (n_st),
        .o_res   (step_res)
    );

    // Held item advances when the result register is free or being emptied
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_s_tready) begin
            n_in_valid = i_s_tvalid;
        end
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = step_res.produce;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= STATE_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (adv) begin
                r_st <= n_st;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch <= i_s_tdata;
        end
        if (adv && step_res.produce) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.char_count, r_out.arg_count, r_out.out_char, r_out.slash_run};
    assign o_m_tuser  = {r_out.arg_end, r_out.char_valid};
    assign o_m_tlast  = r_out.line_end;

`ifndef SYNTHESIS
    // a pending quote only exists inside a quoted part of an argument
    a_pend_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.quote_pend |-> (r_st.in_quotes && r_st.in_arg))
        else $error("quote pending outside quoted argument");

    // backslashes are only counted inside an argument, never with a pending quote
    a_run_in_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.bs_run != '0) |-> (r_st.in_arg && !r_st.quote_pend))
        else $error("backslash run outside argument");

    // after a line end has been stepped, all state is clear
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && step_res.line_end) |=> (r_st == STATE_RESET))
        else $error("state not cleared after line end");

    // an argument end always counts its terminator
    a_end_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[63:48] != 16'd0))
        else $error("argument end with zero character count");

    // no character code is shown without its flag
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[31:16] == 16'd0))
        else $error("character present without char_valid");
`endif

endmodule

// ----- sv/clas_step.sv -----
module clas_step (
    input  logic [15:0]     i_ch,
    input  clas_pkg::t_state i_state,
    output clas_pkg::t_state o_state,
    output clas_pkg::t_res   o_res
);
    import clas_pkg::*;

    t_state                st;
    logic [CHAR_BITS-1:0]  c_raw;
    logic [FIELD_BITS-1:0] c;
    logic                  is_sep;
    logic                  skip;
    logic                  done;
    logic [RUN_BITS-1:0]   run;
    logic [FIELD_BITS-1:0] slashes;
    logic                  cvalid;
    logic [FIELD_BITS-1:0] ochar;
    logic                  aend;
    logic                  lend;
    logic                  produce;
    logic [SUM_BITS-1:0]   sum;

    // Character masked to its width
    assign c_raw  = CHAR_BITS'(i_ch);
    assign c      = FIELD_BITS'(c_raw);
    assign is_sep = (c == C_SPACE) || (c == C_TAB);

    // One parser step
    always_comb begin
        st      = i_state;
        run     = i_state.bs_run;
        skip    = 1'b0;
        done    = 1'b0;
        slashes = '0;
        cvalid  = 1'b0;
        ochar   = '0;
        aend    = 1'b0;
        lend    = 1'b0;

        // between arguments: skip separators, end the line on NUL, start an argument otherwise
        if (!st.in_arg) begin
            if (is_sep) begin
                skip = 1'b1;
            end else if (c == C_NUL) begin
                lend = 1'b1;
            end else begin
                st.in_arg = 1'b1;
                if (st.args != COUNT_MAX) begin
                    st.args = st.args + 1'b1;
                end
            end
        end

        if (!skip && st.in_arg) begin
            // resolve a quote seen inside quotes
            if (st.quote_pend) begin
                st.quote_pend = 1'b0;
                if (c == C_QUOTE) begin
                    cvalid = 1'b1;
                    ochar  = C_QUOTE;
                    done   = 1'b1;
                end else begin
                    st.in_quotes = 1'b0;
                end
            end
            if (!done) begin
                if (c == C_SLASH) begin
                    if (run != RUN_MAX) begin
                        st.bs_run = run + 1'b1;
                    end
                end else begin
                    st.bs_run = '0;
                    if (c == C_QUOTE) begin
                        slashes = FIELD_BITS'(run >> 1);
                        if (run[0]) begin
                            cvalid = 1'b1;
                            ochar  = C_QUOTE;
                        end else if (st.in_quotes) begin
                            st.quote_pend = 1'b1;
                        end else begin
                            st.in_quotes = 1'b1;
                        end
                    end else begin
                        slashes = FIELD_BITS'(run);
                        if (c == C_NUL) begin
                            aend = 1'b1;
                            lend = 1'b1;
                        end else if (!st.in_quotes && is_sep) begin
                            aend      = 1'b1;
                            st.in_arg = 1'b0;
                        end else begin
                            cvalid = 1'b1;
                            ochar  = c;
                        end
                    end
                end
            end
        end

        produce = (slashes != '0) || cvalid || aend || lend;

        // saturating character count
        sum = SUM_BITS'(st.chars) + SUM_BITS'(slashes) + SUM_BITS'(cvalid) + SUM_BITS'(aend);
        if (produce) begin
            st.chars = (sum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(sum);
        end

        o_res.produce    = produce;
        o_res.slash_run  = slashes;
        o_res.char_valid = cvalid;
        o_res.out_char   = ochar;
        o_res.arg_end    = aend;
        o_res.line_end   = lend;
        o_res.arg_count  = FIELD_BITS'(st.args);
        o_res.char_count = FIELD_BITS'(st.chars);

        // line end clears everything
        o_state = lend ? STATE_RESET : st;
    end

endmodule
